@@ hdl/segment_intersection_2d_assert.svh @@
// Assertion macros for the segment intersection RTL, included by the queue.
`ifndef SEGMENT_INTERSECTION_2D_ASSERT_SVH
`define SEGMENT_INTERSECTION_2D_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define SEGX_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("segx assertion failed");

// next-cycle implication
`define SEGX_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("segx assertion failed");

`endif

@@ hdl/segx_pkg.sv @@
// Shared types and constants of the segment intersection block.
package segx_pkg;

  localparam int FIELD_WIDTH = 32;
  localparam int QUEUE_DEPTH = 8;

  localparam logic [0:0]  REG_PARALLEL_THRESHOLD = 1'b0;
  localparam logic [31:0] THRESHOLD_RESET        = 32'd1;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] a_x;
    logic signed [FIELD_WIDTH-1:0] a_y;
    logic signed [FIELD_WIDTH-1:0] b_x;
    logic signed [FIELD_WIDTH-1:0] b_y;
    logic signed [FIELD_WIDTH-1:0] c_x;
    logic signed [FIELD_WIDTH-1:0] c_y;
    logic signed [FIELD_WIDTH-1:0] d_x;
    logic signed [FIELD_WIDTH-1:0] d_y;
  } in_word_t;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] cross_x;
    logic signed [FIELD_WIDTH-1:0] cross_y;
    logic                          within_both;
    logic                          lines_meet;
  } out_word_t;

endpackage

@@ hdl/segx_stream_if.sv @@
// Valid/ready stream interface carrying one word per handshake.
interface segx_stream_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/segment_intersection_2d.sv @@
// Top level: 2D segment intersection with APB threshold register.
//
//  channel | dir | payload                               | handshake
//  in_i    | in  | a_x a_y b_x b_y c_x c_y d_x d_y       | valid/ready
//  out_o   | out | cross_x cross_y within_both lines_meet | valid/ready
//  apb     | in  | parallel_threshold at byte 0          | psel/penable
//
// One word per cycle while out_o is ready; each accepted input word reaches the
// output through the front multiplier stages, the queue and one divider stage
// per quotient bit.
// Reset is asynchronous, active low; no clearing pass.
// An output stall freezes the back pipeline; the 8-word queue lets the front
// keep accepting until its slots are reserved.
module segment_intersection_2d #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  segx_stream_if.sink          in_i,
  segx_stream_if.source        out_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import segx_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;
  localparam int PW = 2 * DW + 1;
  localparam int QW = 2 * W + 2 * DW + 2 * PW + 2;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [31:0]   thr_q;
  logic          push, pop, empty;
  logic [QW-1:0] push_data, pop_data;
  logic [CW-1:0] count;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PARALLEL_THRESHOLD) ? thr_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_PARALLEL_THRESHOLD) begin
      thr_q <= pwdata;
    end
  end

  segx_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_data_i  (in_i.data),
    .in_ready_o (in_i.ready),
    .thr_i      (thr_q),
    .q_count_i  (count),
    .q_push_o   (push),
    .q_data_o   (push_data)
  );

  segx_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .pop_i   (pop),
    .data_o  (pop_data),
    .empty_o (empty),
    .count_o (count)
  );

  segx_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (empty),
    .q_data_i    (pop_data),
    .q_pop_o     (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );
endmodule

@@ hdl/segx_fifo.sv @@
// Short word queue between the front and back parts.
module segx_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic [CW-1:0]    count_o
);
  `include "segment_intersection_2d_assert.svh"

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign data_o  = mem_q[rd_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

  `SEGX_ASSERT_IMP(a_no_push_full, count_q == CW'(DEPTH), !push_i)
  `SEGX_ASSERT_IMP(a_no_pop_empty, count_q == '0, !pop_i)
  `SEGX_ASSERT_NXT(a_count_up, push_i && !pop_i, count_q == $past(count_q) + 1'b1)
  `SEGX_ASSERT_NXT(a_count_down, pop_i && !push_i, count_q == $past(count_q) - 1'b1)
endmodule

@@ hdl/segx_front.sv @@
// Front part: deltas, determinant, parallel and on-segment classification.
module segx_front #(
  parameter int COORD_WIDTH = 32,
  localparam int W  = COORD_WIDTH,
  localparam int DW = W + 1,
  localparam int PW = 2 * DW + 1,
  localparam int QW = 2 * W + 2 * DW + 2 * PW + 2,
  localparam int CW = $clog2(segx_pkg::QUEUE_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  segx_pkg::in_word_t  in_data_i,
  output logic                in_ready_o,
  input  logic [31:0]         thr_i,
  input  logic [CW-1:0]       q_count_i,
  output logic                q_push_o,
  output logic [QW-1:0]       q_data_o
);
  import segx_pkg::*;

  localparam int PRW = 2 * DW;

  typedef struct packed {
    logic signed [W-1:0]  ax;
    logic signed [W-1:0]  ay;
    logic signed [DW-1:0] dx1;
    logic signed [DW-1:0] dy1;
    logic signed [PW-1:0] div;
    logic signed [PW-1:0] mul2;
    logic                 meet;
    logic                 on_seg;
  } qword_t;

  logic signed [W-1:0]   ax, ay, bx, by, cx, cy, dx, dy;
  logic                  s1_v_q, s2_v_q, s3_v_q, push_q;
  logic signed [W-1:0]   s1_ax_q, s1_ay_q, s2_ax_q, s2_ay_q, s3_ax_q, s3_ay_q;
  logic signed [DW-1:0]  s1_dx1_q, s1_dy1_q, s1_dx2_q, s1_dy2_q, s1_ex_q, s1_ey_q;
  logic signed [DW-1:0]  s2_dx1_q, s2_dy1_q, s3_dx1_q, s3_dy1_q;
  logic signed [PRW-1:0] p_da_q, p_db_q, p_1a_q, p_1b_q, p_2a_q, p_2b_q;
  logic signed [PW-1:0]  div_q, mul1_q, mul2_q;
  logic [PW-1:0]         adiv;
  logic                  parallel, out1, out2;
  qword_t                word_d, word_q;
  logic [CW:0]           busy;

  assign ax = in_data_i.a_x[W-1:0];
  assign ay = in_data_i.a_y[W-1:0];
  assign bx = in_data_i.b_x[W-1:0];
  assign by = in_data_i.b_y[W-1:0];
  assign cx = in_data_i.c_x[W-1:0];
  assign cy = in_data_i.c_y[W-1:0];
  assign dx = in_data_i.d_x[W-1:0];
  assign dy = in_data_i.d_y[W-1:0];

  // credit: every word in flight here has a queue slot reserved
  assign busy = (CW + 1)'(q_count_i) + (CW + 1)'(s1_v_q) + (CW + 1)'(s2_v_q)
              + (CW + 1)'(s3_v_q) + (CW + 1)'(push_q);
  assign in_ready_o = (busy < (CW + 1)'(QUEUE_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      push_q <= 1'b0;
    end else begin
      s1_v_q <= in_valid_i && in_ready_o;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      push_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ax_q  <= ax;
    s1_ay_q  <= ay;
    s1_dx1_q <= DW'(bx) - DW'(ax);
    s1_dy1_q <= DW'(by) - DW'(ay);
    s1_dx2_q <= DW'(dx) - DW'(cx);
    s1_dy2_q <= DW'(dy) - DW'(cy);
    s1_ex_q  <= DW'(ax) - DW'(cx);
    s1_ey_q  <= DW'(ay) - DW'(cy);

    s2_ax_q  <= s1_ax_q;
    s2_ay_q  <= s1_ay_q;
    s2_dx1_q <= s1_dx1_q;
    s2_dy1_q <= s1_dy1_q;
    p_da_q   <= s1_dy2_q * s1_dx1_q;
    p_db_q   <= s1_dx2_q * s1_dy1_q;
    p_1a_q   <= s1_dx1_q * s1_ey_q;
    p_1b_q   <= s1_dy1_q * s1_ex_q;
    p_2a_q   <= s1_dx2_q * s1_ey_q;
    p_2b_q   <= s1_dy2_q * s1_ex_q;

    s3_ax_q  <= s2_ax_q;
    s3_ay_q  <= s2_ay_q;
    s3_dx1_q <= s2_dx1_q;
    s3_dy1_q <= s2_dy1_q;
    div_q    <= PW'(p_da_q) - PW'(p_db_q);
    mul1_q   <= PW'(p_1a_q) - PW'(p_1b_q);
    mul2_q   <= PW'(p_2a_q) - PW'(p_2b_q);

    word_q   <= word_d;
  end

  always_comb begin
    adiv     = div_q[PW-1] ? PW'(-div_q) : PW'(div_q);
    parallel = (div_q == '0) || (adiv < thr_i);
    if (div_q[PW-1]) begin
      out1 = (mul1_q > 0) || (mul1_q < div_q);
      out2 = (mul2_q > 0) || (mul2_q < div_q);
    end else begin
      out1 = (mul1_q < 0) || (mul1_q > div_q);
      out2 = (mul2_q < 0) || (mul2_q > div_q);
    end
    word_d.ax     = s3_ax_q;
    word_d.ay     = s3_ay_q;
    word_d.dx1    = s3_dx1_q;
    word_d.dy1    = s3_dy1_q;
    word_d.div    = div_q;
    word_d.mul2   = mul2_q;
    word_d.meet   = !parallel;
    word_d.on_seg = !parallel && !out1 && !out2;
  end

  assign q_push_o = push_q;
  assign q_data_o = word_q;
endmodule

@@ hdl/segx_back.sv @@
// Back part: numerators, pipelined restoring divider, offset and saturation.
module segx_back #(
  parameter int COORD_WIDTH = 32,
  localparam int W  = COORD_WIDTH,
  localparam int DW = W + 1,
  localparam int PW = 2 * DW + 1,
  localparam int QW = 2 * W + 2 * DW + 2 * PW + 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  logic [QW-1:0]       q_data_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output segx_pkg::out_word_t out_data_o
);
  import segx_pkg::*;

  localparam int LOW = W + 2;
  localparam int PLW = LOW + 1 + DW;
  localparam int PHW = 2 * DW;
  localparam int NW  = PW + DW;
  localparam int QB  = W + 2;
  localparam int VW  = W + 4;
  localparam longint VMAXL = (longint'(1) <<< (W - 1)) - 1;
  localparam logic signed [VW-1:0] VMAX = VW'(VMAXL);
  localparam logic signed [VW-1:0] VMIN = VW'(-VMAXL - 1);

  typedef struct packed {
    logic signed [W-1:0]  ax;
    logic signed [W-1:0]  ay;
    logic signed [DW-1:0] dx1;
    logic signed [DW-1:0] dy1;
    logic signed [PW-1:0] div;
    logic signed [PW-1:0] mul2;
    logic                 meet;
    logic                 on_seg;
  } qword_t;

  typedef struct packed {
    logic signed [W-1:0] ax;
    logic signed [W-1:0] ay;
    logic [PW-1:0]       ad;
    logic [PW-1:0]       rx;
    logic [PW-1:0]       ry;
    logic [QB-1:0]       lx;
    logic [QB-1:0]       ly;
    logic [QB-1:0]       qx;
    logic [QB-1:0]       qy;
    logic                nx;
    logic                ny;
    logic                ox;
    logic                oy;
    logic                meet;
    logic                on_seg;
  } dstep_t;

  function automatic logic [PW:0] rem_step(logic [PW-1:0] r, logic b, logic [PW-1:0] d);
    logic [PW:0] t;
    logic [PW:0] diff;
    t    = {r, b};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) rem_step = {1'b1, diff[PW-1:0]};
    else rem_step = {1'b0, t[PW-1:0]};
  endfunction

  function automatic dstep_t div_step(dstep_t s);
    dstep_t      n;
    logic [PW:0] rx;
    logic [PW:0] ry;
    n    = s;
    rx   = rem_step(s.rx, s.lx[QB-1], s.ad);
    ry   = rem_step(s.ry, s.ly[QB-1], s.ad);
    n.rx = rx[PW-1:0];
    n.ry = ry[PW-1:0];
    n.qx = {s.qx[QB-2:0], rx[PW]};
    n.qy = {s.qy[QB-2:0], ry[PW]};
    n.lx = s.lx << 1;
    n.ly = s.ly << 1;
    return n;
  endfunction

  function automatic logic signed [W-1:0] place(logic signed [W-1:0] base, logic [QB-1:0] q,
                                                logic neg, logic ovf);
    logic signed [VW-1:0] v;
    logic signed [VW-1:0] mag;
    mag = VW'(q);
    v   = VW'(base) + (neg ? -mag : mag);
    if (ovf) v = neg ? VMIN : VMAX;
    else if (v > VMAX) v = VMAX;
    else if (v < VMIN) v = VMIN;
    return v[W-1:0];
  endfunction

  logic                  en;
  qword_t                qw;
  logic                  b1_v_q, b2_v_q, b3_v_q;
  logic signed [W-1:0]   b1_ax_q, b1_ay_q, b2_ax_q, b2_ay_q, b3_ax_q, b3_ay_q;
  logic signed [PW-1:0]  b1_div_q, b2_div_q;
  logic                  b1_meet_q, b1_within_q, b2_meet_q, b2_within_q;
  logic                  b3_meet_q, b3_within_q;
  logic signed [PLW-1:0] plx_q, ply_q;
  logic signed [PHW-1:0] phx_q, phy_q;
  logic [NW-1:0]         numx_q, numy_q, anx_q, any_q;
  logic [PW-1:0]         ad_q;
  logic                  nx_q, ny_q;
  dstep_t                init;
  dstep_t                st_q [QB+1];
  logic [QB:0]           sv_q;
  logic                  out_valid_q;
  out_word_t             out_q, out_d;

  assign qw      = q_data_i;
  assign en      = !out_valid_q || out_ready_i;
  assign q_pop_o = en && !q_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q      <= 1'b0;
      b2_v_q      <= 1'b0;
      b3_v_q      <= 1'b0;
      sv_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      b1_v_q      <= !q_empty_i;
      b2_v_q      <= b1_v_q;
      b3_v_q      <= b2_v_q;
      sv_q        <= {sv_q[QB-1:0], b3_v_q};
      out_valid_q <= sv_q[QB];
    end
  end

  always_comb begin
    init        = '0;
    init.ax     = b3_ax_q;
    init.ay     = b3_ay_q;
    init.ad     = ad_q;
    init.rx     = {1'b0, anx_q[NW-1:QB]};
    init.ry     = {1'b0, any_q[NW-1:QB]};
    init.lx     = anx_q[QB-1:0];
    init.ly     = any_q[QB-1:0];
    init.nx     = nx_q;
    init.ny     = ny_q;
    init.ox     = {1'b0, anx_q[NW-1:QB]} >= ad_q;
    init.oy     = {1'b0, any_q[NW-1:QB]} >= ad_q;
    init.meet   = b3_meet_q;
    init.on_seg = b3_within_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_ax_q     <= qw.ax;
      b1_ay_q     <= qw.ay;
      b1_div_q    <= qw.div;
      b1_meet_q   <= qw.meet;
      b1_within_q <= qw.on_seg;
      plx_q       <= $signed({1'b0, qw.mul2[LOW-1:0]}) * qw.dx1;
      ply_q       <= $signed({1'b0, qw.mul2[LOW-1:0]}) * qw.dy1;
      phx_q       <= $signed(qw.mul2[PW-1:LOW]) * qw.dx1;
      phy_q       <= $signed(qw.mul2[PW-1:LOW]) * qw.dy1;

      b2_ax_q     <= b1_ax_q;
      b2_ay_q     <= b1_ay_q;
      b2_div_q    <= b1_div_q;
      b2_meet_q   <= b1_meet_q;
      b2_within_q <= b1_within_q;
      numx_q      <= (NW'(phx_q) << LOW) + NW'(plx_q);
      numy_q      <= (NW'(phy_q) << LOW) + NW'(ply_q);

      b3_ax_q     <= b2_ax_q;
      b3_ay_q     <= b2_ay_q;
      b3_meet_q   <= b2_meet_q;
      b3_within_q <= b2_within_q;
      ad_q        <= b2_div_q[PW-1] ? PW'(-b2_div_q) : PW'(b2_div_q);
      anx_q       <= numx_q[NW-1] ? -numx_q : numx_q;
      any_q       <= numy_q[NW-1] ? -numy_q : numy_q;
      nx_q        <= numx_q[NW-1] ^ b2_div_q[PW-1];
      ny_q        <= numy_q[NW-1] ^ b2_div_q[PW-1];

      st_q[0]     <= init;
      for (int k = 0; k < QB; k++) st_q[k+1] <= div_step(st_q[k]);

      out_q       <= out_d;
    end
  end

  always_comb begin
    out_d = '0;
    if (st_q[QB].meet) begin
      out_d.cross_x     = FIELD_WIDTH'(place(st_q[QB].ax, st_q[QB].qx, st_q[QB].nx,
                                             st_q[QB].ox));
      out_d.cross_y     = FIELD_WIDTH'(place(st_q[QB].ay, st_q[QB].qy, st_q[QB].ny,
                                             st_q[QB].oy));
      out_d.within_both = st_q[QB].on_seg;
      out_d.lines_meet  = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule
